// File: rtl/key_matrix_click_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Key matrix click tracker assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_CLICK_TRACKER_TOP_DEFINES_SVH
`define KEY_MATRIX_CLICK_TRACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define KMCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define KMCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMCT_ASSERT(lbl, prop, msg)
`define KMCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/kmct_pkg.sv
// ----------------------------------------------------------------------------
// Key matrix click tracker package
// Shared types, status codes and defaults.
// ----------------------------------------------------------------------------
package kmct_pkg;

	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 8;

	localparam logic [15:0] WINDOW_RST = 16'd300;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RISE = 2'd1;
	localparam logic [1:0] ST_HELD = 2'd2;
	localparam logic [1:0] ST_FALL = 2'd3;

	typedef struct packed {
		logic        down;
		logic [31:0] press_start;
		logic [31:0] release_time;
		logic [7:0]  clicks;
	} key_entry_t;

endpackage

// File: rtl/kmct_key_store.sv
// ----------------------------------------------------------------------------
// Key state store
// Per-key state memory with valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
`include "key_matrix_click_tracker_top_defines.svh"

module kmct_key_store
	import kmct_pkg::*;
#(
	parameter int NKEYS = ROWS_DEF * COLS_DEF,
	localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output key_entry_t       rd_ent,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  key_entry_t       wr_data
);

	key_entry_t       mem [NKEYS];
	logic [NKEYS-1:0] vld_q;
	key_entry_t       rd_data_q;
	logic             rd_vld_q;
	logic             hit_q;
	key_entry_t       fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			fwd_q     <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
				// same-cycle write to the key being read: take the new data
				hit_q    <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	always_comb begin
		if (hit_q) begin
			rd_ent = fwd_q;
		end else if (rd_vld_q) begin
			rd_ent = rd_data_q;
		end else begin
			rd_ent = '0;
		end
	end

	`KMCT_ASSERT(a_wr_idx_range, wr_en |-> (32'(wr_idx) < NKEYS), "store write out of range")
	`KMCT_ASSERT(a_hit_has_write, (rd_en && wr_en && wr_idx == rd_idx) |=> hit_q, "forward missed")
	`KMCT_ASSERT_ALWAYS(a_rst_clear, !arst_n |-> (vld_q == '0), "valid bits not cleared")

endmodule

// File: rtl/key_matrix_click_tracker_top.sv
// ----------------------------------------------------------------------------
// Key matrix click tracker
// Per-key edge, hold time and multi-click tracking for sampled matrix keys.
// ----------------------------------------------------------------------------
// Each accepted sample passes the input register, then the result register.
// Throughput: one sample per cycle unless the output stalls; each is a
// read-modify-write of its key's entry, the registered memory read plus
// forwarding keeps back-to-back hits.
// Reset: asynchronous; valid bits for all entries clear at once, so every key
// reads as zero state with no clearing pass; window register returns to 300.
`include "key_matrix_click_tracker_top_defines.svh"

module key_matrix_click_tracker_top
	import kmct_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  key_row,
	input  logic [2:0]  key_col,
	input  logic        level,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  key_status,
	output logic [31:0] elapsed_ms,
	output logic [7:0]  click_count,
	output logic        is_down
);

	localparam int NKEYS = ROWS * COLS;
	localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

	logic [15:0] window_q;

	logic             in_fire;
	logic             in_range;
	logic [IDX_W-1:0] key_idx;

	logic             valid_s1;
	logic             in_range_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             level_s1;
	logic [31:0]      now_s1;

	logic       out_free;
	logic       s1_fire;
	logic       wr_en;
	key_entry_t ent;
	key_entry_t nxt;
	logic [31:0] base;
	logic [31:0] delta;
	logic [1:0]  status;
	logic [31:0] elapsed;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] elapsed_q;
	logic [7:0]  clicks_q;
	logic        down_q;

	logic        down_st;
	logic        edge_out;
	logic        rise_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	assign in_range = (32'(key_row) < ROWS) && (32'(key_col) < COLS);
	assign key_idx  = in_range ? IDX_W'(32'(key_row) * COLS + 32'(key_col)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_range_s1 <= in_range;
			idx_s1      <= key_idx;
			level_s1    <= level;
			now_s1      <= now_ms;
		end
	end

	assign wr_en = s1_fire && in_range_s1;

	kmct_key_store #(
		.NKEYS(NKEYS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_fire),
		.rd_idx (key_idx),
		.rd_ent (ent),
		.wr_en  (wr_en),
		.wr_idx (idx_s1),
		.wr_data(nxt)
	);

	// one subtract serves both hold time and release gap
	assign base  = level_s1 ? ent.press_start : ent.release_time;
	assign delta = now_s1 - base;

	always_comb begin
		nxt     = ent;
		status  = ST_IDLE;
		elapsed = '0;
		if (!in_range_s1) begin
			status  = ST_IDLE;
			elapsed = '0;
		end else if (level_s1) begin
			if (!ent.down) begin
				if (ent.clicks != 8'hFF) begin
					nxt.clicks = ent.clicks + 8'd1;
				end
				nxt.down        = 1'b1;
				nxt.press_start = now_s1;
				status          = ST_RISE;
			end else begin
				status  = ST_HELD;
				elapsed = delta;
			end
		end else begin
			if (!ent.down) begin
				status  = ST_IDLE;
				elapsed = delta;
				if (delta > {16'b0, window_q}) begin
					nxt.clicks = '0;
				end
			end else begin
				nxt.down         = 1'b0;
				nxt.release_time = now_s1;
				nxt.press_start  = '0;
				status           = ST_FALL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q  <= status;
			elapsed_q <= elapsed;
			clicks_q  <= in_range_s1 ? nxt.clicks : 8'd0;
			down_q    <= in_range_s1 && nxt.down;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_status  = status_q;
	assign elapsed_ms  = elapsed_q;
	assign click_count = clicks_q;
	assign is_down     = down_q;

	assign down_st  = (key_status == ST_RISE) || (key_status == ST_HELD);
	assign edge_out = out_valid && ((key_status == ST_RISE) || (key_status == ST_FALL));
	assign rise_out = out_valid && (key_status == ST_RISE);

	`KMCT_ASSERT(a_down_match, out_valid |-> (is_down == down_st), "is_down disagrees with status")
	`KMCT_ASSERT(a_edge_zero, edge_out |-> (elapsed_ms == '0), "edge with nonzero elapsed")
	`KMCT_ASSERT(a_rise_clicks, rise_out |-> (click_count != 8'd0), "rising edge without click")
	`KMCT_ASSERT(a_full_stall, (valid_s1 && out_valid && !out_ready) |-> !in_ready, "stall ignored")
	`KMCT_ASSERT_ALWAYS(a_rst_out, !arst_n |-> !out_valid, "result valid in reset")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Key matrix click tracker testbench
// Sends key samples over the valid/ready input and predicts each result with
// a per-key model of edge, hold time and multi-click state. Every result is
// checked in order. The run covers directed corner samples, then random
// phases under several window settings (zero, full scale, random), hot keys,
// a click count driven into saturation, bursty input and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top
	import kmct_pkg::*;
();

	localparam int NKEYS       = ROWS_DEF * COLS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] elapsed;
		logic [7:0]  clicks;
		logic        down;
	} key_report_t;

	typedef enum int {RX_ALWAYS, RX_ALTERNATE, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	class click_scoreboard;
		key_entry_t  keys [NKEYS];
		logic [15:0] window;
		key_report_t pending [$];
		int errors, checked, samples, clears, saturated;
		int status_hits [4];

		function new();
			window = WINDOW_RST;
			foreach (keys[i]) keys[i] = '0;
		endfunction

		function void set_window(logic [15:0] w);
			window = w;
		endfunction

		// Predict the report for one accepted sample and update the key entry.
		function void note_sample(logic [2:0] row, logic [2:0] col, logic lvl,
				logic [31:0] now);
			key_report_t r;
			int k;
			r = '0;
			samples++;
			if (int'(row) >= ROWS_DEF || int'(col) >= COLS_DEF) begin
				pending.push_back(r);
				return;
			end
			k = int'(row) * COLS_DEF + int'(col);
			if (lvl) begin
				if (!keys[k].down) begin
					if (keys[k].clicks == 8'hFF)
						saturated++;
					else
						keys[k].clicks++;
					keys[k].down = 1'b1;
					keys[k].press_start = now;
					r.status = ST_RISE;
				end else begin
					r.status = ST_HELD;
					r.elapsed = now - keys[k].press_start;
				end
			end else if (!keys[k].down) begin
				r.status = ST_IDLE;
				r.elapsed = now - keys[k].release_time;
				if (r.elapsed > {16'h0, window}) begin
					if (keys[k].clicks != 0) clears++;
					keys[k].clicks = '0;
				end
			end else begin
				keys[k].down = 1'b0;
				keys[k].release_time = now;
				keys[k].press_start = '0;
				r.status = ST_FALL;
			end
			r.clicks = keys[k].clicks;
			r.down = keys[k].down;
			status_hits[r.status]++;
			pending.push_back(r);
		endfunction

		function void mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field,
				exp_val, act_val);
		endfunction

		function void check_result(logic [1:0] st, logic [31:0] el, logic [7:0] ck,
				logic dn);
			key_report_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0h elapsed %0h clicks %0h down %0h",
					$time, st, el, ck, dn);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (st !== e.status) mismatch("key_status", 32'(e.status), 32'(st));
			if (el !== e.elapsed) mismatch("elapsed_ms", e.elapsed, el);
			if (ck !== e.clicks) mismatch("click_count", 32'(e.clicks), 32'(ck));
			if (dn !== e.down) mismatch("is_down", 32'(e.down), 32'(dn));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  key_row;
	logic [2:0]  key_col;
	logic        level;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  key_status;
	logic [31:0] elapsed_ms;
	logic [7:0]  click_count;
	logic        is_down;

	click_scoreboard sb = new();

	// stimulus-side view of each key, used to aim times at the window edges
	bit [31:0] last_now [NKEYS];
	bit [31:0] fall_now [NKEYS];
	bit        sent_level [NKEYS];
	int        cur_window = 300;
	bit        hold_req;
	int        hold_cnt;
	int        idle_cycles;
	rx_mode_t  rx_mode = RX_ALWAYS;
	int        rx_left;

	key_matrix_click_tracker_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_row    (key_row),
		.key_col    (key_col),
		.level      (level),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_status (key_status),
		.elapsed_ms (elapsed_ms),
		.click_count(click_count),
		.is_down    (is_down)
	);

	always #2 clk = ~clk;

	// Receiver: stall pattern is redrawn at random intervals; long hold-off on request.
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 100);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_ALWAYS:    out_ready <= 1'b1;
				RX_ALTERNATE: out_ready <= ~out_ready;
				RX_MOSTLY:    out_ready <= ($urandom_range(0, 9) < 7);
				default:      out_ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(key_status, elapsed_ms, click_count, is_down);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
				$time, idle_cycles, sb.pending.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_sample(input logic [2:0] row, input logic [2:0] col,
			input logic lvl, input logic [31:0] now);
		int k;
		k = int'(row) * COLS_DEF + int'(col);
		in_valid <= 1'b1;
		key_row <= row;
		key_col <= col;
		level <= lvl;
		now_ms <= now;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(row, col, lvl, now);
		if (sent_level[k] && !lvl) fall_now[k] = now;
		sent_level[k] = lvl;
		last_now[k] = now;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [15:0] w);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_window(w);
		cur_window = int'(w);
	endtask

	// Back-to-back corner samples at the reset window of 300 ms.
	task automatic directed_samples();
		send_sample(3'd0, 3'd0, 1'b0, 32'd0);
		send_sample(3'd7, 3'd7, 1'b0, 32'hFFFF_FFFF);   // never released, full gap
		send_sample(3'd7, 3'd7, 1'b1, 32'd5);
		send_sample(3'd7, 3'd7, 1'b1, 32'd5);
		send_sample(3'd7, 3'd7, 1'b1, 32'd4);           // held time wraps
		send_sample(3'd7, 3'd7, 1'b1, 32'd1005);
		send_sample(3'd7, 3'd7, 1'b0, 32'd1010);
		send_sample(3'd7, 3'd7, 1'b0, 32'd1310);        // gap equals window: count kept
		send_sample(3'd7, 3'd7, 1'b1, 32'd1320);
		send_sample(3'd7, 3'd7, 1'b0, 32'd1330);
		send_sample(3'd7, 3'd7, 1'b0, 32'd1631);        // one past window: count clears
		send_sample(3'd7, 3'd7, 1'b1, 32'd1640);
		send_sample(3'd0, 3'd7, 1'b1, 32'h8000_0000);
		send_sample(3'd7, 3'd0, 1'b1, 32'h7FFF_FFFF);
		send_sample(3'd0, 3'd7, 1'b1, 32'h7FFF_FFFF);
		send_sample(3'd0, 3'd7, 1'b0, 32'h8000_0000);
		send_sample(3'd0, 3'd7, 1'b0, 32'h7FFF_FFFF);
		send_sample(3'd5, 3'd2, 1'b1, 32'h1234_5678);
		send_sample(3'd2, 3'd5, 1'b1, 32'h1234_5679);
		send_sample(3'd5, 3'd2, 1'b0, 32'h1234_5700);
		send_sample(3'd2, 3'd5, 1'b0, 32'h1234_5701);
		send_sample(3'd7, 3'd7, 1'b0, 32'd1700);
	endtask

	// Random samples in bursts. A focus key, if given, toggles quickly to pile
	// up clicks; the rest mostly hit a small hot set with times near the window.
	task automatic random_phase(input int n, input int focus, input int focus_pct,
			input bit hold);
		int hot [4];
		int burst_left, gap, k;
		logic lvl;
		logic [31:0] base, now;
		burst_left = 0;
		foreach (hot[j]) hot[j] = $urandom_range(0, NKEYS - 1);
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			if (hold && i == n / 2) hold_req = 1'b1;
			if (focus >= 0 && $urandom_range(0, 99) < focus_pct) begin
				k = focus;
				lvl = !sent_level[k];
				now = last_now[k] + $urandom_range(1, 50);
			end else begin
				k = ($urandom_range(0, 2) != 0) ? hot[$urandom_range(0, 3)]
					: $urandom_range(0, NKEYS - 1);
				if (k == focus) k = (k + 1) % NKEYS;
				lvl = 1'($urandom_range(0, 1));
				base = (!lvl && $urandom_range(0, 1)) ? fall_now[k] : last_now[k];
				case ($urandom_range(0, 9))
					0:       now = base;
					1:       now = base + cur_window;
					2:       now = base + cur_window + 1;
					3:       now = base + cur_window - 1;
					4, 5, 6: now = base + $urandom_range(0, cur_window + 20);
					7:       now = base + $urandom_range(0, 5);
					default: now = $urandom;
				endcase
			end
			send_sample(3'(k / COLS_DEF), 3'(k % COLS_DEF), lvl, now);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		key_row <= '0;
		key_col <= '0;
		level <= 1'b0;
		now_ms <= '0;
		out_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_samples();
		write_window(16'h0000);
		random_phase(200, -1, 0, 1'b1);
		write_window(16'hFFFF);
		random_phase(600, $urandom_range(0, NKEYS - 1), 90, 1'b0);
		write_window(16'($urandom_range(1, 16'hFFFE)));
		random_phase(150, -1, 0, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d samples, %0d results checked, windows 300/0/65535/%0d",
			sb.samples, sb.checked, cur_window);
		$display("  rises %0d, holds %0d, falls %0d, idle %0d, clears %0d, sat %0d",
			sb.status_hits[ST_RISE], sb.status_hits[ST_HELD], sb.status_hits[ST_FALL],
			sb.status_hits[ST_IDLE], sb.clears, sb.saturated);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
